// ===== sv/bcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_pkg: shared definitions for the byte-coded CPU execute block
// Sizes, opcode and status codes, register map and the structs passed
// between the execute unit and the top level.
// ----------------------------------------------------------------------------
package bcc_pkg;

  // Machine sizes (REG_COUNT is a power of two: register numbers use low bits)
  localparam int REG_COUNT   = 4;
  localparam int STACK_DEPTH = 16;
  localparam int REG_IDX_W   = $clog2(REG_COUNT);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
  localparam int PLEN_W      = 9;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef logic [7:0] byte_t;

  typedef enum logic [7:0] {
    OP_NOP   = 8'h00,
    OP_LOAD  = 8'h01,
    OP_ADD   = 8'h02,
    OP_SUB   = 8'h03,
    OP_STORE = 8'h04,
    OP_READ  = 8'h09,
    OP_WRITE = 8'h0A,
    OP_JMP   = 8'h0B,
    OP_CALL  = 8'h0C,
    OP_RET   = 8'h0D,
    OP_BEQ   = 8'h0E,
    OP_BNE   = 8'h0F,
    OP_INT   = 8'h10
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  // Register index, taken from the word address bits
  typedef enum logic [PADDR_W-3:0] {
    REG_PROGRAM_LENGTH = 1'b0
  } cfg_reg_t;

  typedef struct packed {
    byte_t opcode;
    byte_t first_operand;
    byte_t second_operand;
    byte_t read_value;
  } item_t;

  typedef struct packed {
    byte_t   next_pc;
    logic    out_valid;
    byte_t   out_value;
    logic    store_valid;
    byte_t   store_address;
    byte_t   store_data;
    logic    interrupt_raised;
    status_t status;
    logic    halted;
  } result_t;

  // Architectural state changes produced by one instruction
  typedef struct packed {
    logic                 reg_we;
    logic [REG_IDX_W-1:0] reg_idx;
    byte_t                reg_data;
    byte_t                pc;
    logic [SP_W-1:0]      sp;
    logic                 push_en;
    byte_t                push_data;
  } exec_update_t;

endpackage

// ===== sv/bcc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_if: valid/ready channels of the byte-coded CPU execute block
// Instruction channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface bcc_instr_if;
  import bcc_pkg::*;

  logic  valid;
  logic  ready;
  byte_t opcode;
  byte_t first_operand;
  byte_t second_operand;
  byte_t read_value;

  modport source (
    output valid, opcode, first_operand, second_operand, read_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, first_operand, second_operand, read_value,
    output ready
  );
endinterface

interface bcc_result_if;
  import bcc_pkg::*;

  logic       valid;
  logic       ready;
  byte_t      next_pc;
  logic       out_valid;
  byte_t      out_value;
  logic       store_valid;
  byte_t      store_address;
  byte_t      store_data;
  logic       interrupt_raised;
  logic [1:0] status;
  logic       halted;

  modport source (
    output valid, next_pc, out_valid, out_value, store_valid, store_address,
           store_data, interrupt_raised, status, halted,
    input  ready
  );
  modport sink (
    input  valid, next_pc, out_valid, out_value, store_valid, store_address,
           store_data, interrupt_raised, status, halted,
    output ready
  );
endinterface

// ===== sv/bcc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_ram: generic RAM, one write port, two registered read ports
// Read data updates only when the read enable is high and holds otherwise.
// ----------------------------------------------------------------------------
module bcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered reads, old data on a same-cycle write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== sv/bcc_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_cfg: configuration register port
// APB-style slave holding the program length register.
// ----------------------------------------------------------------------------
module bcc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [bcc_pkg::PDATA_W-1:0]  pwdata,
  output logic [bcc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [bcc_pkg::PLEN_W-1:0]   program_length
);
  import bcc_pkg::*;

  logic     wr_en;
  cfg_reg_t reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Program length register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (wr_en && (reg_sel == REG_PROGRAM_LENGTH)) begin
      program_length <= pwdata[PLEN_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_sel == REG_PROGRAM_LENGTH) begin
      prdata = PDATA_W'(program_length);
    end
  end

endmodule

// ===== sv/bcc_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcc_exec: instruction execute logic
// Decodes one instruction against the current machine state and produces
// the result transaction and the state update.
// ----------------------------------------------------------------------------
module bcc_exec (
  input  bcc_pkg::item_t                item,
  input  bcc_pkg::byte_t                ra_val,
  input  bcc_pkg::byte_t                rb_val,
  input  bcc_pkg::byte_t                pc,
  input  logic [bcc_pkg::SP_W-1:0]      sp,
  input  bcc_pkg::byte_t                stack_top,
  input  logic [bcc_pkg::PLEN_W-1:0]    program_length,
  output bcc_pkg::result_t              result,
  output bcc_pkg::exec_update_t         upd
);
  import bcc_pkg::*;

  byte_t npc;
  logic  halted_before;

  assign halted_before = {1'b0, pc} >= program_length;

  // Decode and execute
  always_comb begin
    result         = '0;
    result.status  = ST_OK;
    upd            = '0;
    upd.reg_idx    = item.first_operand[REG_IDX_W-1:0];
    upd.reg_data   = item.second_operand;
    upd.pc         = pc;
    upd.sp         = sp;
    upd.push_data  = pc + 8'd2;
    npc            = pc + 8'd1;

    if (!halted_before) begin
      unique case (item.opcode)
        OP_NOP: begin
          npc = pc + 8'd1;
        end
        OP_LOAD: begin
          upd.reg_we = 1'b1;
          npc        = pc + 8'd3;
        end
        OP_ADD: begin
          upd.reg_we   = 1'b1;
          upd.reg_data = ra_val + rb_val;
          npc          = pc + 8'd3;
        end
        OP_SUB: begin
          upd.reg_we   = 1'b1;
          upd.reg_data = ra_val - rb_val;
          npc          = pc + 8'd3;
        end
        OP_STORE: begin
          result.store_valid   = 1'b1;
          result.store_address = item.second_operand;
          result.store_data    = ra_val;
          npc                  = pc + 8'd3;
        end
        OP_READ: begin
          upd.reg_we   = 1'b1;
          upd.reg_data = item.read_value;
          npc          = pc + 8'd2;
        end
        OP_WRITE: begin
          result.out_valid = 1'b1;
          result.out_value = ra_val;
          npc              = pc + 8'd2;
        end
        OP_JMP: begin
          npc = item.first_operand;
        end
        OP_CALL: begin
          // Push the return address unless the stack is full
          if (sp < SP_W'(STACK_DEPTH)) begin
            upd.push_en = 1'b1;
            upd.sp      = sp + SP_W'(1);
            npc         = item.first_operand;
          end else begin
            result.status = ST_OVERFLOW;
            npc           = pc + 8'd2;
          end
        end
        OP_RET: begin
          // Pop the return address unless the stack is empty
          if (sp != '0) begin
            upd.sp = sp - SP_W'(1);
            npc    = stack_top;
          end else begin
            result.status = ST_UNDERFLOW;
          end
        end
        OP_BEQ: begin
          npc = (ra_val == 8'd0) ? item.second_operand : pc + 8'd3;
        end
        OP_BNE: begin
          npc = (ra_val != 8'd0) ? item.second_operand : pc + 8'd3;
        end
        OP_INT: begin
          result.interrupt_raised = 1'b1;
        end
        default: begin
          result.status = ST_UNKNOWN;
        end
      endcase
      upd.pc = npc;
    end

    result.next_pc = upd.pc;
    result.halted  = {1'b0, upd.pc} >= program_length;
  end

endmodule

// ===== sv/byte_coded_cpu_execute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_coded_cpu_execute: execute stage of a small 8-bit byte-coded CPU
// Runs one fetched instruction per transaction and reports next pc, events,
// status and halt.
// ----------------------------------------------------------------------------
// The block retires one instruction per clock cycle as long as results are taken.
// An accepted transaction sits in an operand stage, where the general registers
// are read from a two-port register RAM (with a bypass from the instruction
// executing as they are read), then executes and lands in the result register.
// The instruction channel stays ready while the operand stage or the result
// register is empty or the result is being drained, so a new instruction enters
// every cycle as long as results are taken. No clearing pass follows reset: the
// block accepts instructions from the first cycle. The user must write
// program_length at byte address 0 and only while the block is idle; it does not check.
// ----------------------------------------------------------------------------
module byte_coded_cpu_execute (
  input  logic                         clk,
  input  logic                         rst,
  bcc_instr_if.sink                    instr,
  bcc_result_if.source                 result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [bcc_pkg::PDATA_W-1:0]  pwdata,
  output logic [bcc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import bcc_pkg::*;

  logic [PLEN_W-1:0]    program_length;

  // Architectural state
  byte_t                pc;
  logic [SP_W-1:0]      sp;
  byte_t                stack [STACK_DEPTH];
  logic [REG_COUNT-1:0] written;

  // Operand stage
  logic                 stage_valid;
  item_t                stage;
  logic                 a_byp;
  logic                 b_byp;
  logic                 a_written;
  logic                 b_written;
  byte_t                byp_data;

  // Result register
  logic                 res_valid;
  result_t              res;

  logic                 res_free;
  logic                 accept;
  logic                 fire;
  logic [REG_IDX_W-1:0] ra_in;
  logic [REG_IDX_W-1:0] rb_in;
  byte_t                rdata_a;
  byte_t                rdata_b;
  byte_t                ra_val;
  byte_t                rb_val;
  logic [SP_W-1:0]      sp_m1;
  byte_t                stack_top;
  result_t              exec_res;
  exec_update_t         upd;
  logic                 wr_fire;

  // Configuration register
  bcc_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .program_length (program_length)
  );

  // Handshake control
  assign res_free    = !res_valid || result.ready;
  assign instr.ready = !stage_valid || res_free;
  assign accept      = instr.valid && instr.ready;
  assign fire        = stage_valid && res_free;
  assign wr_fire     = fire && upd.reg_we;

  assign ra_in = instr.first_operand[REG_IDX_W-1:0];
  assign rb_in = instr.second_operand[REG_IDX_W-1:0];

  // General register file
  bcc_ram #(
    .WIDTH (8),
    .DEPTH (REG_COUNT)
  ) u_regs (
    .clk     (clk),
    .we      (wr_fire),
    .waddr   (upd.reg_idx),
    .wdata   (upd.reg_data),
    .re      (accept),
    .raddr_a (ra_in),
    .raddr_b (rb_in),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Select operands: bypass, then RAM, then reset value of an unwritten register
  assign ra_val = a_byp ? byp_data : (a_written ? rdata_a : 8'd0);
  assign rb_val = b_byp ? byp_data : (b_written ? rdata_b : 8'd0);

  // Top of the return stack
  assign sp_m1     = sp - SP_W'(1);
  assign stack_top = stack[sp_m1[STK_IDX_W-1:0]];

  bcc_exec u_exec (
    .item           (stage),
    .ra_val         (ra_val),
    .rb_val         (rb_val),
    .pc             (pc),
    .sp             (sp),
    .stack_top      (stack_top),
    .program_length (program_length),
    .result         (exec_res),
    .upd            (upd)
  );

  // Operand stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (instr.ready) begin
      stage_valid <= instr.valid;
    end
  end

  // Operand stage payload and bypass capture
  always_ff @(posedge clk) begin
    if (accept) begin
      stage.opcode         <= instr.opcode;
      stage.first_operand  <= instr.first_operand;
      stage.second_operand <= instr.second_operand;
      stage.read_value     <= instr.read_value;
      a_byp                <= wr_fire && (upd.reg_idx == ra_in);
      b_byp                <= wr_fire && (upd.reg_idx == rb_in);
      a_written            <= written[ra_in];
      b_written            <= written[rb_in];
      byp_data             <= upd.reg_data;
    end
  end

  // Machine state update on execute
  always_ff @(posedge clk) begin
    if (rst) begin
      pc      <= '0;
      sp      <= '0;
      written <= '0;
    end else if (fire) begin
      pc <= upd.pc;
      sp <= upd.sp;
      if (upd.reg_we) begin
        written[upd.reg_idx] <= 1'b1;
      end
    end
  end

  // Return stack push
  always_ff @(posedge clk) begin
    if (fire && upd.push_en) begin
      stack[sp[STK_IDX_W-1:0]] <= upd.push_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= exec_res;
    end
  end

  // Drive the result channel
  assign result.valid            = res_valid;
  assign result.next_pc          = res.next_pc;
  assign result.out_valid        = res.out_valid;
  assign result.out_value        = res.out_value;
  assign result.store_valid      = res.store_valid;
  assign result.store_address    = res.store_address;
  assign result.store_data       = res.store_data;
  assign result.interrupt_raised = res.interrupt_raised;
  assign result.status           = res.status;
  assign result.halted           = res.halted;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the byte-coded CPU execute block
// Runs directed instructions, then random programs under several program
// lengths. The bench keeps its own model of the registers, pc and return
// stack and checks every result field against it, with random stalls on
// both channels and one long result back-pressure stretch.
// ----------------------------------------------------------------------------
module tb;
  import bcc_pkg::*;

  localparam int MAX_CYCLES   = 200000;
  localparam int RUN_ITEMS    = 1000;
  localparam int PHASE_ITEMS  = 120;
  localparam int MAX_PHASES   = 40;
  localparam int DRAIN_CYCLES = 4;
  localparam int CALM_START   = 1000;
  localparam int CALM_END     = 1500;
  localparam int STALL_AT     = 600;
  localparam int STALL_CYCLES = 64;
  localparam int MAX_PRINTS   = 50;

  // Opcodes outside the instruction set
  localparam byte_t OP_GAP_FIRST = 8'h05;
  localparam byte_t OP_GAP_LAST  = 8'h08;
  localparam byte_t OP_TOP       = 8'hFF;

  localparam opcode_t KNOWN_OPS [13] = '{OP_NOP, OP_LOAD, OP_ADD, OP_SUB, OP_STORE,
                                         OP_READ, OP_WRITE, OP_JMP, OP_CALL, OP_RET,
                                         OP_BEQ, OP_BNE, OP_INT};

  typedef struct {
    bit         is_cfg;
    logic [8:0] length;
    item_t      instr;
    bit         typed;
    result_t    want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  bcc_instr_if  instr_ch ();
  bcc_result_if result_ch ();

  byte_coded_cpu_execute u_dut (
    .clk     (clk),
    .rst     (rst),
    .instr   (instr_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Machine model
  byte_t      gpr_model [REG_COUNT];
  byte_t      ret_stack_model [STACK_DEPTH];
  byte_t      pc_model;
  int         sp_model;
  logic [8:0] plen_model;

  result_t pending_results [$];
  dir_row_t directed [$];

  int cycles;
  int errors;
  int accepted_cnt;
  int checked_cnt;
  int stall_left;
  bit stall_done;
  int n_executed, n_halted, n_store, n_write, n_irq, n_lengths;
  int n_status [4];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // Print one line per mismatch, up to a cap, and count all of them
  task automatic flag_error(string msg);
    if (errors < MAX_PRINTS) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                           checked_cnt, name, got, want));
  endtask

  function automatic bit idle_now();
    if (cycles >= CALM_START && cycles < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < 25;
  endfunction

  // Execute one instruction on the model and return the expected result
  function automatic result_t exec_instr(item_t it);
    result_t r;
    byte_t   npc;
    int      ra, rb;
    r  = '0;
    ra = it.first_operand % REG_COUNT;
    rb = it.second_operand % REG_COUNT;
    if ({1'b0, pc_model} >= plen_model) begin
      r.next_pc = pc_model;
      r.halted  = 1'b1;
      n_halted++;
      return r;
    end
    n_executed++;
    npc = pc_model + 8'd1;
    case (it.opcode)
      OP_NOP: ;
      OP_LOAD: begin
        gpr_model[ra] = it.second_operand;
        npc = pc_model + 8'd3;
      end
      OP_ADD: begin
        gpr_model[ra] = gpr_model[ra] + gpr_model[rb];
        npc = pc_model + 8'd3;
      end
      OP_SUB: begin
        gpr_model[ra] = gpr_model[ra] - gpr_model[rb];
        npc = pc_model + 8'd3;
      end
      OP_STORE: begin
        r.store_valid   = 1'b1;
        r.store_address = it.second_operand;
        r.store_data    = gpr_model[ra];
        npc = pc_model + 8'd3;
        n_store++;
      end
      OP_READ: begin
        gpr_model[ra] = it.read_value;
        npc = pc_model + 8'd2;
      end
      OP_WRITE: begin
        r.out_valid = 1'b1;
        r.out_value = gpr_model[ra];
        npc = pc_model + 8'd2;
        n_write++;
      end
      OP_JMP: npc = it.first_operand;
      OP_CALL: begin
        if (sp_model < STACK_DEPTH) begin
          ret_stack_model[sp_model] = pc_model + 8'd2;
          sp_model++;
          npc = it.first_operand;
        end else begin
          r.status = ST_OVERFLOW;
          npc = pc_model + 8'd2;
        end
      end
      OP_RET: begin
        if (sp_model > 0) begin
          sp_model--;
          npc = ret_stack_model[sp_model];
        end else begin
          r.status = ST_UNDERFLOW;
        end
      end
      OP_BEQ: npc = (gpr_model[ra] == 8'd0) ? it.second_operand : pc_model + 8'd3;
      OP_BNE: npc = (gpr_model[ra] != 8'd0) ? it.second_operand : pc_model + 8'd3;
      OP_INT: begin
        r.interrupt_raised = 1'b1;
        n_irq++;
      end
      default: r.status = ST_UNKNOWN;
    endcase
    pc_model  = npc;
    r.next_pc = npc;
    r.halted  = ({1'b0, npc} >= plen_model);
    n_status[r.status]++;
    return r;
  endfunction

  function automatic result_t plain(byte_t npc, status_t st, logic halt);
    result_t r;
    r         = '0;
    r.next_pc = npc;
    r.status  = st;
    r.halted  = halt;
    return r;
  endfunction

  function automatic dir_row_t row(byte_t op, byte_t a, byte_t b, byte_t rd,
                                   bit typed = 1'b0, result_t want = '0);
    dir_row_t d;
    d.is_cfg = 1'b0;
    d.length = '0;
    d.instr  = '{opcode: op, first_operand: a, second_operand: b, read_value: rd};
    d.typed  = typed;
    d.want   = want;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(logic [8:0] length);
    dir_row_t d;
    d        = row(OP_NOP, 8'h00, 8'h00, 8'h00);
    d.is_cfg = 1'b1;
    d.length = length;
    return d;
  endfunction

  // Jump targets mostly land inside the program so execution keeps going
  function automatic byte_t pick_target();
    if (plen_model == 0 || $urandom_range(0, 99) < 20) return byte_t'($urandom_range(0, 255));
    return byte_t'($urandom_range(0, plen_model - 1));
  endfunction

  function automatic item_t rand_instr(bit noisy);
    item_t it;
    it.first_operand  = byte_t'($urandom_range(0, 255));
    it.second_operand = byte_t'($urandom_range(0, 255));
    it.read_value     = byte_t'($urandom_range(0, 255));
    if (noisy) begin
      it.opcode = byte_t'($urandom_range(0, 255));
    end else begin
      it.opcode = KNOWN_OPS[$urandom_range(0, 12)];
      if (it.opcode == OP_JMP || it.opcode == OP_CALL) it.first_operand = pick_target();
      if (it.opcode == OP_BEQ || it.opcode == OP_BNE) it.second_operand = pick_target();
    end
    return it;
  endfunction

  // Offer one instruction, with random gaps, and record its expectation on accept
  task automatic send_instr(item_t it, bit typed, result_t want);
    result_t r;
    @(negedge clk);
    while (stall_left == 0 && idle_now()) begin
      instr_ch.valid <= 1'b0;
      @(negedge clk);
    end
    instr_ch.valid          <= 1'b1;
    instr_ch.opcode         <= it.opcode;
    instr_ch.first_operand  <= it.first_operand;
    instr_ch.second_operand <= it.second_operand;
    instr_ch.read_value     <= it.read_value;
    @(posedge clk);
    while (!instr_ch.ready) @(posedge clk);
    accepted_cnt++;
    r = exec_instr(it);
    if (typed) r = want;
    pending_results = {pending_results, r};
  endtask

  // Drain the block, write program_length, then read it back
  task automatic write_length(logic [8:0] length);
    @(negedge clk);
    instr_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_PROGRAM_LENGTH, 2'b00};
    pwdata  <= PDATA_W'(length);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    plen_model = length;
    n_lengths++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== PDATA_W'(length))
      flag_error($sformatf("program_length read back 0x%0h, wrote 0x%0h", prdata, length));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (!stall_done && accepted_cnt >= STALL_AT) begin
      result_ch.ready <= 1'b0;
      stall_left      <= STALL_CYCLES;
      stall_done      <= 1'b1;
    end else begin
      result_ch.ready <= !idle_now();
    end
  end

  // Compare every result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result transaction with no instruction pending");
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", result_ch.next_pc, want.next_pc);
        check_field("out_valid", result_ch.out_valid, want.out_valid);
        check_field("out_value", result_ch.out_value, want.out_value);
        check_field("store_valid", result_ch.store_valid, want.store_valid);
        check_field("store_address", result_ch.store_address, want.store_address);
        check_field("store_data", result_ch.store_data, want.store_data);
        check_field("interrupt_raised", result_ch.interrupt_raised, want.interrupt_raised);
        check_field("status", result_ch.status, want.status);
        check_field("halted", result_ch.halted, want.halted);
      end
      checked_cnt++;
    end
  end

  // Watchdog
  initial begin
    while (cycles < MAX_CYCLES) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    item_t it;
    int    ph, n, k, len, nc;
    // Hold everything quiet through reset
    rst                     = 1'b1;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    instr_ch.valid          = 1'b0;
    instr_ch.opcode         = '0;
    instr_ch.first_operand  = '0;
    instr_ch.second_operand = '0;
    instr_ch.read_value     = '0;
    pc_model                = '0;
    sp_model                = 0;
    plen_model              = '0;
    foreach (gpr_model[i]) gpr_model[i] = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    directed = '{
      // length zero after reset: already halted
      row(OP_NOP,       8'h00, 8'h00, 8'h00, 1'b1, plain(8'h00, ST_OK, 1'b1)),
      cfg_row(9'd256),
      row(OP_LOAD,      8'h00, 8'hFF, 8'h00, 1'b1, plain(8'h03, ST_OK, 1'b0)),
      row(OP_LOAD,      8'hFD, 8'h01, 8'hFF),
      // wrap on add, borrow on sub, register numbers from high operands
      row(OP_ADD,       8'h00, 8'h01, 8'h00),
      row(OP_SUB,       8'h04, 8'hFD, 8'h00),
      row(OP_STORE,     8'hFC, 8'hFF, 8'h00),
      row(OP_READ,      8'h02, 8'h00, 8'hA5),
      row(OP_WRITE,     8'hFE, 8'h00, 8'h00),
      // branches taken and not taken
      row(OP_BEQ,       8'h03, 8'h80, 8'h00),
      row(OP_BNE,       8'h03, 8'h10, 8'h00),
      row(OP_BNE,       8'h02, 8'hF0, 8'h00),
      row(OP_BEQ,       8'h02, 8'h00, 8'h00),
      row(OP_INT,       8'hFF, 8'hFF, 8'hFF),
      // unknown opcodes, then return with an empty stack
      row(OP_GAP_FIRST, 8'h00, 8'h00, 8'h00, 1'b1, plain(8'hF5, ST_UNKNOWN, 1'b0)),
      row(OP_GAP_LAST,  8'h00, 8'h00, 8'h00, 1'b1, plain(8'hF6, ST_UNKNOWN, 1'b0)),
      row(OP_TOP,       8'hFF, 8'hFF, 8'hFF, 1'b1, plain(8'hF7, ST_UNKNOWN, 1'b0)),
      row(OP_RET,       8'h00, 8'h00, 8'h00, 1'b1, plain(8'hF8, ST_UNDERFLOW, 1'b0)),
      // pc wraps from the top of memory
      row(OP_JMP,       8'hFF, 8'h00, 8'h00),
      row(OP_NOP,       8'h00, 8'h00, 8'h00, 1'b1, plain(8'h00, ST_OK, 1'b0)),
      row(OP_CALL,      8'h40, 8'h00, 8'h00),
      row(OP_CALL,      8'hFE, 8'h00, 8'h00),
      row(OP_RET,       8'h00, 8'h00, 8'h00),
      row(OP_RET,       8'h00, 8'h00, 8'h00),
      // run up to a short program end, then sit halted
      cfg_row(9'd16),
      row(OP_JMP,       8'h0F, 8'h00, 8'h00),
      row(OP_NOP,       8'h00, 8'h00, 8'h00, 1'b1, plain(8'h10, ST_OK, 1'b1)),
      row(OP_LOAD,      8'h00, 8'h55, 8'h00, 1'b1, plain(8'h10, ST_OK, 1'b1)),
      cfg_row(9'd256)
    };
    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_length(directed[i].length);
      else send_instr(directed[i].instr, directed[i].typed, directed[i].want);
    end

    // Random programs under a rotation of program lengths
    ph = 0;
    while (accepted_cnt < RUN_ITEMS && ph < MAX_PHASES) begin
      case (ph % 6)
        0, 3:    len = 256;
        1:       len = $urandom_range(2, 254);
        2:       len = 255;
        4:       len = 0;
        default: len = 1;
      endcase
      // steer the pc inside the next program while it can still move
      if (len > 0 && {1'b0, pc_model} < plen_model) begin
        it        = rand_instr(1'b0);
        it.opcode = OP_JMP;
        it.first_operand = byte_t'($urandom_range(0, len - 1));
        send_instr(it, 1'b0, '0);
      end
      write_length(len[8:0]);
      n = (len < 2) ? 20 : PHASE_ITEMS;
      k = 0;
      while (k < n) begin
        if ($urandom_range(0, 99) < 3) begin
          // fill the return stack past its depth, then empty it past zero
          nc = STACK_DEPTH - sp_model + $urandom_range(1, 3);
          repeat (nc) begin
            it        = rand_instr(1'b0);
            it.opcode = OP_CALL;
            it.first_operand = pick_target();
            send_instr(it, 1'b0, '0);
          end
          repeat (STACK_DEPTH + $urandom_range(1, 2)) begin
            it        = rand_instr(1'b0);
            it.opcode = OP_RET;
            send_instr(it, 1'b0, '0);
            k++;
          end
          k += nc;
        end else begin
          send_instr(rand_instr($urandom_range(0, 99) < 15), 1'b0, '0);
          k++;
        end
      end
      ph++;
    end

    // Drain and let any stray result show up
    @(negedge clk);
    instr_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4 * DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d instructions and %0d while halted over %0d length settings",
             n_executed, n_halted, n_lengths);
    $display("Saw %0d stores, %0d writes, %0d interrupts, %0d unknown, %0d underflow, %0d overflow",
             n_store, n_write, n_irq, n_status[ST_UNKNOWN], n_status[ST_UNDERFLOW],
             n_status[ST_OVERFLOW]);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bcc_pkg.sv
sv/bcc_if.sv
sv/bcc_ram.sv
sv/bcc_cfg.sv
sv/bcc_exec.sv
sv/byte_coded_cpu_execute.sv
tb/tb.sv
